// ===== design/mts_pkg.sv =====
// Shared types and constants for the min-tracking stack.
// No dependencies; imported by the control and top-level modules.
`timescale 1ns / 1ps

package mts_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 8;   // width of the reported entry count

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // one result beat, as produced by the control unit
   typedef struct packed {
      logic                      is_empty;
      logic        [COUNT_W-1:0] entry_count;
      logic signed [DATA_W-1:0]  min_value;
      logic signed [DATA_W-1:0]  top_value;
      logic signed [DATA_W-1:0]  popped_value;
      logic                      accepted;
   } rsp_type;

endpackage

// ===== design/min_tracking_stack_top.sv =====
// Top level of the min-tracking stack: request/response stream ports and result register.
// Depends on mts_pkg and mts_ctrl.
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit values that also reports the minimum of
// its contents.
// req channel: one beat per operation; req_tuser is the kind (0 push,
//   1 pop), req_tdata the value to push (ignored for a pop).
// rsp channel: exactly one beat per request, in order; rsp_tuser flags
//   whether the operation was performed (push when full and pop when empty
//   are refused), rsp_tdata carries the popped value and the top, minimum,
//   count and emptiness after the operation.
// Response timing: a push, a refused operation or a pop that empties the
//   stack shows its response the cycle after the request beat; a pop that
//   leaves entries passes through ST_POP first, as the new top is read from
//   the entry RAM's registered read port. Pushes are taken one per cycle
//   while responses drain; such a pop holds off new requests until done.
// The top entry and its running minimum live in registers, the entries
//   below in one RAM holding value and running minimum side by side.
// Reset empties the stack at once; RAM contents need no clearing.
// A stalled response holds in the result register; a new request is taken
//   only while that register is empty or draining in the same cycle.
module min_tracking_stack_top import mts_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic          clock,
   input  logic          reset,

   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,  // push_value[31:0]
   input  logic          req_tuser,  // kind

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,  // popped_value[31:0], top_value[63:32],
                                     // min_value[95:64], entry_count[103:96],
                                     // is_empty[104], zero pad [111:105]
   output logic          rsp_tuser   // accepted
);

   logic    start, busy, done;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign start      = req_tvalid && req_tready;

   mts_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .kind       (req_tuser),
      .push_value (req_tdata),
      .busy       (busy),
      .done       (done),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.accepted;
   assign rsp_tdata  = {7'd0, rsp_ff.is_empty, rsp_ff.entry_count, rsp_ff.min_value,
                        rsp_ff.top_value, rsp_ff.popped_value};

endmodule

// ===== design/mts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mts_ctrl.sv =====
// Stack control: top entry held in registers, lower entries in mts_ram.
// Depends on mts_pkg and mts_ram.
`timescale 1ns / 1ps

module mts_ctrl import mts_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     kind,
   input  logic signed [DATA_W-1:0] push_value,
   output logic                     busy,
   output logic                     done,
   output rsp_type                  result
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] top_val_ff, top_val_in;
   logic signed [DATA_W-1:0] top_min_ff, top_min_in;
   logic signed [DATA_W-1:0] popped_ff, popped_in;

   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [2*DATA_W-1:0]      wr_data, rd_data;

   logic                     is_empty, is_full;
   logic [CW-1:0]            count_m1, count_m2;
   logic [CW+COUNT_W-1:0]    count_ext;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);

   // memory slot i holds entry i for every entry below the top
   assign wr_addr = count_m1[AW-1:0];
   assign wr_data = {top_min_ff, top_val_ff};
   assign rd_addr = count_m2[AW-1:0];

   mts_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      top_val_in = top_val_ff;
      top_min_in = top_min_ff;
      popped_in  = popped_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      done       = 1'b0;
      result     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (kind == KIND_PUSH) begin
                  done = 1'b1;
                  if (!is_full) begin
                     wr_en      = !is_empty;
                     top_val_in = push_value;
                     top_min_in = (!is_empty && !(push_value < top_min_ff)) ?
                                  top_min_ff : push_value;
                     count_in   = count_ff + CW'(1);
                     result.accepted = 1'b1;
                  end
               end else begin
                  if (is_empty) begin
                     done = 1'b1;
                  end else if (count_ff == CW'(1)) begin
                     done     = 1'b1;
                     count_in = '0;
                     result.accepted     = 1'b1;
                     result.popped_value = top_val_ff;
                  end else begin
                     // new top comes back from memory next cycle
                     rd_en     = 1'b1;
                     popped_in = top_val_ff;
                     count_in  = count_m1;
                     state_in  = ST_POP;
                  end
               end
            end
         end
         ST_POP: begin
            done       = 1'b1;
            top_val_in = rd_data[DATA_W-1:0];
            top_min_in = rd_data[2*DATA_W-1:DATA_W];
            state_in   = ST_IDLE;
            result.accepted     = 1'b1;
            result.popped_value = popped_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      count_ext          = {{COUNT_W{1'b0}}, count_in};
      result.entry_count = count_ext[COUNT_W-1:0];
      result.is_empty    = (count_in == '0);
      if (count_in != '0) begin
         result.top_value = top_val_in;
         result.min_value = top_min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      popped_ff  <= popped_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
